### src/crp_pkg.sv
// Shared types and codes for the clock replacement table with pinning.
`timescale 1ns / 1ps

package crp_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ID_BITS_DEF = 16;

    localparam logic [2:0] CMD_ACCESS = 3'd0;
    localparam logic [2:0] CMD_PIN    = 3'd1;
    localparam logic [2:0] CMD_UNPIN  = 3'd2;
    localparam logic [2:0] CMD_EVICT  = 3'd3;
    localparam logic [2:0] CMD_ADD    = 3'd4;
    localparam logic [2:0] CMD_REMOVE = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_DUP    = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] frame_num;
    } t_crp_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] victim_id;
    } t_crp_rsp;

    // Sequencer status toward the handshake logic.
    typedef struct packed {
        logic idle;
        logic done;
    } t_crp_ctl_st;

endpackage

### src/clock_replacement_with_pinning.sv
// Top level of the clock replacement table with pinning.
//
//   channel   direction  handshake                    payload
//   request   in         i_req_valid / o_req_ready    i_req (command, frame_num)
//   response  out        o_res_valid / i_res_ready    o_res (status, victim_id)
//
// One request at a time runs through the sequencer. A search over n tracked
// ids visits each entry in two states (address, then compare on the
// registered read port of the id store) before the action state for access,
// pin, unpin, add and remove; remove also passes a move state when an entry
// moves. Evict steps the hand one entry per cycle for up to two turns.
// Reset clears the count, hand and all flags; ids need none. A finished
// response waits in the output register; the sequencer holds in its final
// state while that register is full and not taken.
`timescale 1ns / 1ps

module clock_replacement_with_pinning #(
    parameter int ENTRIES = crp_pkg::ENTRIES_DEF,
    parameter int ID_BITS = crp_pkg::ID_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  crp_pkg::t_crp_req i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output crp_pkg::t_crp_rsp o_res
);
    import crp_pkg::*;

    t_crp_ctl_st ctl_st;
    t_crp_rsp    ctl_rsp;
    logic        start;
    logic        ack;
    logic        r_res_valid;
    t_crp_rsp    r_res;

    // Take a request only while the sequencer is idle.
    assign o_req_ready = ctl_st.idle;
    assign start       = i_req_valid && ctl_st.idle;

    // Move the response into the output register when it is free or draining.
    assign ack = ctl_st.done && (!r_res_valid || i_res_ready);

    crp_ctrl #(
        .ENTRIES (ENTRIES),
        .ID_BITS (ID_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_req.command),
        .i_id    (ID_BITS'(i_req.frame_num)),
        .i_ack   (ack),
        .o_st    (ctl_st),
        .o_rsp   (ctl_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (ack) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
        if (ack) begin
            r_res <= ctl_rsp;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

### src/crp_id_mem.sv
// Frame id store: one write port, one registered read port.
`timescale 1ns / 1ps

module crp_id_mem #(
    parameter int DEPTH = crp_pkg::ENTRIES_DEF,
    parameter int WIDTH = crp_pkg::ID_BITS_DEF,
    parameter int AW    = $clog2(crp_pkg::ENTRIES_DEF)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/crp_ctrl.sv
// Sequencer: id search, flag updates, clock sweep and entry moves.
`timescale 1ns / 1ps

module crp_ctrl #(
    parameter int ENTRIES = crp_pkg::ENTRIES_DEF,
    parameter int ID_BITS = crp_pkg::ID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0]           i_cmd,
    input  logic [ID_BITS-1:0]   i_id,
    input  logic                 i_ack,
    output crp_pkg::t_crp_ctl_st o_st,
    output crp_pkg::t_crp_rsp    o_rsp
);
    import crp_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int STP_W = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_ACT,
        S_MOVE,
        S_EV_STEP,
        S_EV_RD,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_cmd, n_cmd;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic               r_found, n_found;
    logic [STP_W-1:0]   r_steps, n_steps;
    logic [IDX_W-1:0]   r_hand, n_hand;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [ENTRIES-1:0] r_pinned, n_pinned;
    logic [ENTRIES-1:0] r_ref, n_ref;
    t_crp_rsp           r_rsp, n_rsp;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ID_BITS-1:0] mem_rdata;

    logic [CNT_W-1:0]   hand_inc;
    logic [IDX_W-1:0]   hand_next;
    logic [CNT_W-1:0]   last;
    logic [IDX_W-1:0]   hand_rm;

    crp_id_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (ID_BITS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Hand advance, modulo the current count.
    assign hand_inc  = CNT_W'(r_hand) + CNT_W'(1);
    assign hand_next = (hand_inc == r_used) ? '0 : hand_inc[IDX_W-1:0];
    assign last      = r_used - CNT_W'(1);
    assign hand_rm   = (r_hand == r_slot) ? hand_next : r_hand;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_found   = r_found;
        n_steps   = r_steps;
        n_hand    = r_hand;
        n_used    = r_used;
        n_pinned  = r_pinned;
        n_ref     = r_ref;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd;
                    n_id  = i_id;
                    n_idx = '0;
                    case (i_cmd) inside
                        CMD_ACCESS, CMD_PIN, CMD_UNPIN, CMD_ADD, CMD_REMOVE: begin
                            n_state = S_FIND_RD;
                        end
                        CMD_EVICT: begin
                            if (r_used == '0) begin
                                n_rsp   = '{status: ST_ABSENT, victim_id: '0};
                                n_state = S_DONE;
                            end else begin
                                if (CNT_W'(r_hand) >= r_used) begin
                                    n_hand = '0;
                                end
                                n_steps = '0;
                                n_state = S_EV_STEP;
                            end
                        end
                        default: begin
                            n_rsp   = '{status: ST_OK, victim_id: '0};
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_FIND_RD: begin
                if (r_idx == r_used) begin
                    n_found = 1'b0;
                    n_state = S_ACT;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_FIND_CMP;
                end
            end

            S_FIND_CMP: begin
                if (mem_rdata == r_id) begin
                    n_found = 1'b1;
                    n_slot  = r_idx[IDX_W-1:0];
                    n_state = S_ACT;
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_FIND_RD;
                end
            end

            S_ACT: begin
                n_rsp   = '{status: ST_OK, victim_id: '0};
                n_state = S_DONE;
                case (r_cmd) inside
                    CMD_ACCESS, CMD_PIN, CMD_UNPIN: begin
                        if (!r_found) begin
                            n_rsp.status = ST_ABSENT;
                        end else if (r_cmd == CMD_ACCESS) begin
                            n_ref[r_slot] = 1'b1;
                        end else if (r_cmd == CMD_PIN) begin
                            n_pinned[r_slot] = 1'b1;
                        end else begin
                            n_pinned[r_slot] = 1'b0;
                            n_ref[r_slot]    = 1'b1;
                        end
                    end
                    CMD_ADD: begin
                        if (r_found) begin
                            n_rsp.status = ST_DUP;
                        end else if (r_used == CNT_W'(ENTRIES)) begin
                            n_rsp.status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_used[IDX_W-1:0];
                            mem_wdata = r_id;
                            n_pinned[r_used[IDX_W-1:0]] = 1'b0;
                            n_ref[r_used[IDX_W-1:0]]    = 1'b0;
                            n_used = r_used + CNT_W'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        if (!r_found) begin
                            n_rsp.status = ST_ABSENT;
                        end else begin
                            n_used = last;
                            if (last == '0 || CNT_W'(hand_rm) >= last) begin
                                n_hand = '0;
                            end else begin
                                n_hand = hand_rm;
                            end
                            // Fill the hole with the last entry.
                            if (r_slot != last[IDX_W-1:0]) begin
                                n_pinned[r_slot] = r_pinned[last[IDX_W-1:0]];
                                n_ref[r_slot]    = r_ref[last[IDX_W-1:0]];
                                mem_re    = 1'b1;
                                mem_raddr = last[IDX_W-1:0];
                                n_state   = S_MOVE;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_MOVE: begin
                mem_we    = 1'b1;
                mem_waddr = r_slot;
                mem_wdata = mem_rdata;
                n_state   = S_DONE;
            end

            S_EV_STEP: begin
                if (r_steps == {r_used, 1'b0}) begin
                    n_rsp   = '{status: ST_ABSENT, victim_id: '0};
                    n_state = S_DONE;
                end else begin
                    n_steps = r_steps + STP_W'(1);
                    n_hand  = hand_next;
                    if (!r_pinned[r_hand]) begin
                        if (r_ref[r_hand]) begin
                            n_ref[r_hand] = 1'b0;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = r_hand;
                            n_state   = S_EV_RD;
                        end
                    end
                end
            end

            S_EV_RD: begin
                n_rsp   = '{status: ST_OK, victim_id: 16'(mem_rdata)};
                n_state = S_DONE;
            end

            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hand   <= '0;
            r_used   <= '0;
            r_pinned <= '0;
            r_ref    <= '0;
        end else begin
            r_state  <= n_state;
            r_hand   <= n_hand;
            r_used   <= n_used;
            r_pinned <= n_pinned;
            r_ref    <= n_ref;
        end
        r_cmd   <= n_cmd;
        r_id    <= n_id;
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_found <= n_found;
        r_steps <= n_steps;
        r_rsp   <= n_rsp;
    end

    assign o_st.idle = (r_state == S_IDLE);
    assign o_st.done = (r_state == S_DONE);
    assign o_rsp     = r_rsp;

endmodule
